FILE: hdl/vst_pkg.sv
// vst_pkg: shared types and codes for the versioned snapshot table.
// Holds the request and response beat structs, command and status codes.
// No dependencies.
`default_nettype none

package vst_pkg;

    localparam int INDEX_W = 6;
    localparam int SNAP_W  = 16;
    localparam int ALEN_W  = 7;
    localparam int PADDR_W = 3;

    // commands
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_SNAP   = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADIDX = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_SNAP   = 2'd3;

    localparam logic [SNAP_W-1:0] COUNTER_MAX = 16'hFFFF;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE_LENGTH = 3'd0;
    localparam logic [ALEN_W-1:0]  ACTIVE_LENGTH_RST  = 7'd64;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [INDEX_W-1:0] index;
        logic signed [31:0] value;
        logic [SNAP_W-1:0] snap_id;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [SNAP_W-1:0]  snap_number;
        logic [1:0]         status;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/vst_ram.sv
// vst_ram: simple dual-port synchronous RAM, one write and one registered read.
// Used for the history store and the per-entry history counts.
// No dependencies.
`default_nettype none

module vst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/vst_seq.sv
// vst_seq: command sequencer for the versioned snapshot table.
// Owns the snapshot counter, the count and history memories and the result register.
// Depends on vst_pkg and vst_ram.
`default_nettype none

module vst_seq #(
    parameter int ENTRIES       = 64,
    parameter int HISTORY_DEPTH = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [vst_pkg::ALEN_W-1:0]    active_length,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire vst_pkg::req_t                 req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output vst_pkg::rsp_t                      rsp
);

    // only entries that a 6-bit index can reach are stored
    localparam int MAX_IDX   = 1 << vst_pkg::INDEX_W;
    localparam int CNT_DEPTH = (ENTRIES < MAX_IDX) ? ENTRIES : MAX_IDX;
    localparam int IDX_W     = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int ST_DEPTH  = CNT_DEPTH * HISTORY_DEPTH;
    localparam int ST_AW     = $clog2(ST_DEPTH);
    localparam int SNAP_W    = vst_pkg::SNAP_W;
    localparam int ENT_W     = SNAP_W + VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_SETCHK,
        S_SEARCH,
        S_FETCH,
        S_DONE
    } state_t;

    function automatic logic [ST_AW-1:0] slot_addr(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] slot);
        slot_addr = ST_AW'(32'(idx) * HISTORY_DEPTH + 32'(slot));
    endfunction

    state_t                   state_reg, state_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0]   val_reg, val_next;
    logic [SNAP_W-1:0]        sid_reg, sid_next;
    logic [SNAP_W-1:0]        counter_reg, counter_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [CNT_DEPTH-1:0]     cvalid_reg, cvalid_next;
    vst_pkg::rsp_t            res_reg, res_next;
    logic                     st_we_reg, st_we_next;
    logic [ST_AW-1:0]         st_waddr_reg, st_waddr_next;
    logic [ENT_W-1:0]         st_wdata_reg, st_wdata_next;
    logic                     cn_we_reg, cn_we_next;
    logic [CNT_W-1:0]         cn_wdata_reg, cn_wdata_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    vst_pkg::rsp_t            rsp_reg, rsp_next;

    logic                     out_free;
    logic                     idx_ok;
    logic                     commit;
    logic [ST_AW-1:0]         st_raddr;
    logic [ENT_W-1:0]         st_rdata;
    logic [IDX_W-1:0]         cn_raddr;
    logic [CNT_W-1:0]         cn_rdata;
    logic [SNAP_W-1:0]        ent_snap;
    logic [VALUE_WIDTH-1:0]   ent_val;
    logic [CNT_W-1:0]         n_cnt;
    logic [CNT_W-1:0]         lo_n, hi_n, mid_n;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign commit    = (state_reg == S_DONE) && out_free;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign idx_ok = (vst_pkg::ALEN_W'(req.index) < active_length)
                 && (32'(req.index) < ENTRIES);

    assign ent_snap = st_rdata[ENT_W-1 -: SNAP_W];
    assign ent_val  = st_rdata[VALUE_WIDTH-1:0];
    assign cn_raddr = req.index[IDX_W-1:0];

    // history memory: one pair per slot, snapshot number on top
    vst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (commit && st_we_reg),
        .waddr (st_waddr_reg),
        .wdata (st_wdata_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // count memory; entries never written read as zero through cvalid
    vst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt (
        .clk   (clk),
        .we    (commit && cn_we_reg),
        .waddr (idx_reg),
        .wdata (cn_wdata_reg),
        .raddr (cn_raddr),
        .rdata (cn_rdata)
    );

    // sequencer next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        sid_next      = sid_reg;
        counter_next  = counter_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        cvalid_next   = cvalid_reg;
        res_next      = res_reg;
        st_we_next    = st_we_reg;
        st_waddr_next = st_waddr_reg;
        st_wdata_next = st_wdata_reg;
        cn_we_next    = cn_we_reg;
        cn_wdata_next = cn_wdata_reg;
        st_raddr      = slot_addr(idx_reg, mid_reg);
        n_cnt         = cvalid_reg[idx_reg] ? cn_rdata : '0;
        lo_n          = lo_reg;
        hi_n          = hi_reg;
        mid_n         = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    idx_next   = req.index[IDX_W-1:0];
                    val_next   = VALUE_WIDTH'(req.value);
                    sid_next   = req.snap_id;
                    res_next   = '0;
                    st_we_next = 1'b0;
                    cn_we_next = 1'b0;
                    state_next = S_DONE;
                    unique case (req.cmd)
                        vst_pkg::CMD_SET:
                        begin
                            if (!idx_ok)
                            begin
                                res_next.status = vst_pkg::ST_BADIDX;
                            end
                            else
                            begin
                                state_next = S_CNT;
                            end
                        end
                        vst_pkg::CMD_SNAP:
                        begin
                            if (counter_reg == vst_pkg::COUNTER_MAX)
                            begin
                                res_next.status = vst_pkg::ST_SNAP;
                            end
                            else
                            begin
                                res_next.snap_number = counter_reg;
                                counter_next         = counter_reg + 1'b1;
                            end
                        end
                        vst_pkg::CMD_GET:
                        begin
                            if (!idx_ok)
                            begin
                                res_next.status = vst_pkg::ST_BADIDX;
                            end
                            else if (req.snap_id >= counter_reg)
                            begin
                                res_next.status = vst_pkg::ST_SNAP;
                            end
                            else
                            begin
                                state_next = S_CNT;
                            end
                        end
                        default:
                        begin
                            // unused command: all-zero result
                        end
                    endcase
                end
            end

            // count is back; if non-empty, set reads newest pair, get searches
            S_CNT:
            begin
                cnt_next = n_cnt;
                if (cmd_reg == vst_pkg::CMD_SET)
                begin
                    if (n_cnt == '0)
                    begin
                        st_we_next    = 1'b1;
                        st_waddr_next = slot_addr(idx_reg, '0);
                        st_wdata_next = {counter_reg, val_reg};
                        cn_we_next    = 1'b1;
                        cn_wdata_next = CNT_W'(1);
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        st_raddr   = slot_addr(idx_reg, n_cnt - 1'b1);
                        state_next = S_SETCHK;
                    end
                end
                else
                begin
                    lo_next = '0;
                    hi_next = n_cnt;
                    if (n_cnt == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mid_next   = n_cnt >> 1;
                        st_raddr   = slot_addr(idx_reg, n_cnt >> 1);
                        state_next = S_SEARCH;
                    end
                end
            end

            // overwrite newest pair, append, or report a full history
            S_SETCHK:
            begin
                state_next = S_DONE;
                if (ent_snap == counter_reg)
                begin
                    st_we_next    = 1'b1;
                    st_waddr_next = slot_addr(idx_reg, cnt_reg - 1'b1);
                    st_wdata_next = {counter_reg, val_reg};
                end
                else if (32'(cnt_reg) >= HISTORY_DEPTH)
                begin
                    res_next.status = vst_pkg::ST_FULL;
                end
                else
                begin
                    st_we_next    = 1'b1;
                    st_waddr_next = slot_addr(idx_reg, cnt_reg);
                    st_wdata_next = {counter_reg, val_reg};
                    cn_we_next    = 1'b1;
                    cn_wdata_next = cnt_reg + 1'b1;
                end
            end

            // one probe per cycle: compare the returned pair, issue the next read
            S_SEARCH:
            begin
                if (ent_snap <= sid_reg)
                begin
                    lo_n = mid_reg + 1'b1;
                    hi_n = hi_reg;
                end
                else
                begin
                    lo_n = lo_reg;
                    hi_n = mid_reg;
                end
                lo_next = lo_n;
                hi_next = hi_n;
                if (lo_n < hi_n)
                begin
                    mid_n    = lo_n + ((hi_n - lo_n) >> 1);
                    mid_next = mid_n;
                    st_raddr = slot_addr(idx_reg, mid_n);
                end
                else if (lo_n != '0)
                begin
                    st_raddr   = slot_addr(idx_reg, lo_n - 1'b1);
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                res_next.read_value = 32'(signed'(ent_val));
                state_next          = S_DONE;
            end

            // memory writes and the result beat go out together
            S_DONE:
            begin
                if (out_free)
                begin
                    if (cn_we_reg)
                    begin
                        cvalid_next[idx_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            sid_reg       <= '0;
            counter_reg   <= '0;
            cnt_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            cvalid_reg    <= '0;
            res_reg       <= '0;
            st_we_reg     <= 1'b0;
            st_waddr_reg  <= '0;
            st_wdata_reg  <= '0;
            cn_we_reg     <= 1'b0;
            cn_wdata_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            sid_reg       <= sid_next;
            counter_reg   <= counter_next;
            cnt_reg       <= cnt_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            cvalid_reg    <= cvalid_next;
            res_reg       <= res_next;
            st_we_reg     <= st_we_next;
            st_waddr_reg  <= st_waddr_next;
            st_wdata_reg  <= st_wdata_next;
            cn_we_reg     <= cn_we_next;
            cn_wdata_reg  <= cn_wdata_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/versioned_snapshot_table.sv
// Versioned snapshot table: one command beat in, one result beat out.
// Snap, bad index, future id and unused commands go from the accepted beat straight to the result;
// set reads the count and, for a non-empty history, the newest pair; get reads the count, then
// binary-searches a non-empty history, one history read per probe, and fetches the matching pair.
// One command at a time; the next beat is taken the cycle after the result is registered.
// Reset clears counts (valid bits), the snapshot counter and sets active_length to 64.
`default_nettype none

module versioned_snapshot_table #(
    parameter int ENTRIES       = 64,
    parameter int HISTORY_DEPTH = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB-style configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vst_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // command channel
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire vst_pkg::req_t                 req,
    // result channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output vst_pkg::rsp_t                      rsp
);

    logic [vst_pkg::ALEN_W-1:0] active_length_reg, active_length_next;
    logic                       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == vst_pkg::ADDR_ACTIVE_LENGTH);

    // configuration register write
    always_comb
    begin
        active_length_next = active_length_reg;
        if (psel && penable && pwrite && cfg_hit)
        begin
            active_length_next = pwdata[vst_pkg::ALEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_length_reg <= vst_pkg::ACTIVE_LENGTH_RST;
        end
        else
        begin
            active_length_reg <= active_length_next;
        end
    end

    // readback
    assign prdata = cfg_hit ? 32'(active_length_reg) : '0;

    vst_seq #(
        .ENTRIES       (ENTRIES),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_length (active_length_reg),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp)
    );

endmodule

`default_nettype wire

FILE: dv/tb_versioned_snapshot_table.sv
// Self-checking testbench for versioned_snapshot_table: command beats in, result beats out,
// with an APB register write between phases. A scoreboard model predicts every result beat.
// Depends on vst_pkg (hdl/vst_pkg.sv) and the versioned_snapshot_table RTL.
module tb_versioned_snapshot_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES    = 64;
    localparam int HDEPTH         = 16;
    localparam int QUEUE_CAP      = 32;
    localparam int CFG_GAP        = 12;    // settle cycles before a register write
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_AT     = 1600;  // result count that starts the long receiver stall
    localparam int HOLDOFF_CYCLES = 500;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [vst_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    vst_pkg::req_t                req = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    vst_pkg::rsp_t                rsp;

    versioned_snapshot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // table model: per-entry history of (snapshot, value) pairs
    logic [vst_pkg::SNAP_W-1:0] hist_snap [NUM_ENTRIES][HDEPTH];
    logic signed [31:0]         hist_val  [NUM_ENTRIES][HDEPTH];
    int                         hist_len  [NUM_ENTRIES];
    logic [vst_pkg::SNAP_W-1:0] snap_count = '0;
    logic [vst_pkg::ALEN_W-1:0] active_len = vst_pkg::ACTIVE_LENGTH_RST;

    vst_pkg::req_t cmd_queue[$];
    vst_pkg::rsp_t pending_results[$];
    vst_pkg::rsp_t want;
    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_idle_pct = 0;
    int            gen_snaps = 0;
    logic [5:0]    hot_idx [4];
    int            mismatches = 0;
    int            results_seen = 0;
    int            cmd_tally [4] = '{0, 0, 0, 0};
    int            status_seen [4] = '{0, 0, 0, 0};
    int            holdoff_left = 0;
    bit            holdoff_done = 1'b0;
    int            quiet_cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit index_live(input logic [5:0] ix);
        return {1'b0, ix} < active_len;
    endfunction

    // advance the model by one command and return the result beat it produces
    function automatic vst_pkg::rsp_t apply_command(input vst_pkg::req_t c);
        vst_pkg::rsp_t o;
        int            n;
        int            k;
        logic [5:0]    ix;
        o = '0;
        ix = c.index;
        case (c.cmd)
            vst_pkg::CMD_SET: begin
                if (!index_live(ix)) begin
                    o.status = vst_pkg::ST_BADIDX;
                end else begin
                    n = hist_len[ix];
                    // no snapshot since the newest pair: overwrite in place
                    if (n > 0 && hist_snap[ix][n-1] == snap_count) begin
                        hist_val[ix][n-1] = c.value;
                    end else if (n >= HDEPTH) begin
                        o.status = vst_pkg::ST_FULL;
                    end else begin
                        hist_snap[ix][n] = snap_count;
                        hist_val[ix][n] = c.value;
                        hist_len[ix] = n + 1;
                    end
                end
            end
            vst_pkg::CMD_SNAP: begin
                if (snap_count == vst_pkg::COUNTER_MAX) begin
                    o.status = vst_pkg::ST_SNAP;
                end else begin
                    o.snap_number = snap_count;
                    snap_count = snap_count + 1'b1;
                end
            end
            vst_pkg::CMD_GET: begin
                if (!index_live(ix)) begin
                    o.status = vst_pkg::ST_BADIDX;
                end else if (c.snap_id >= snap_count) begin
                    o.status = vst_pkg::ST_SNAP;
                end else begin
                    // newest pair not newer than the requested id; empty history reads zero
                    k = hist_len[ix] - 1;
                    while (k >= 0 && hist_snap[ix][k] > c.snap_id)
                        k--;
                    if (k >= 0)
                        o.read_value = hist_val[ix][k];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic vst_pkg::req_t mk_cmd(input logic [1:0] op, input logic [5:0] ix,
                                             input logic [31:0] v, input logic [15:0] sid);
        vst_pkg::req_t c;
        c.cmd = op;
        c.index = ix;
        c.value = v;
        c.snap_id = sid;
        return c;
    endfunction

    // random command biased toward a few hot entries so histories fill up
    function automatic vst_pkg::req_t random_command();
        vst_pkg::req_t c;
        int unsigned   p;
        p = $urandom_range(0, 99);
        if (p < 40)
            c.cmd = vst_pkg::CMD_SET;
        else if (p < 65)
            c.cmd = vst_pkg::CMD_SNAP;
        else if (p < 98)
            c.cmd = vst_pkg::CMD_GET;
        else
            c.cmd = vst_pkg::CMD_UNUSED;
        if ($urandom_range(0, 3) == 0)
            c.index = 6'($urandom_range(0, 63));
        else
            c.index = hot_idx[$urandom_range(0, 3)];
        case ($urandom_range(0, 7))
            0: c.value = 32'h8000_0000;
            1: c.value = 32'h7FFF_FFFF;
            2: c.value = 32'h0000_0000;
            3: c.value = 32'hFFFF_FFFF;
            default: c.value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: c.snap_id = 16'($urandom);
            1: c.snap_id = 16'(gen_snaps);
            default: c.snap_id = (gen_snaps == 0) ? 16'd0
                                                  : 16'($urandom_range(0, gen_snaps - 1));
        endcase
        return c;
    endfunction

    task automatic push_item(input vst_pkg::req_t c);
        while (cmd_queue.size() >= QUEUE_CAP)
            @(negedge clk);
        cmd_queue = {cmd_queue, c};
        if (c.cmd == vst_pkg::CMD_SNAP && gen_snaps < 65535)
            gen_snaps++;
    endtask

    task automatic run_random(input int n);
        int eff;
        eff = (active_len == 0 || active_len > NUM_ENTRIES) ? NUM_ENTRIES : active_len;
        foreach (hot_idx[i])
            hot_idx[i] = 6'($urandom_range(0, eff - 1));
        repeat (n)
            push_item(random_command());
    endtask

    // sender stops until every command has been answered
    task automatic wait_idle();
        while (cmd_queue.size() > 0 || req_valid || pending_results.size() > 0)
            @(negedge clk);
        repeat (CFG_GAP) @(negedge clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= vst_pkg::ADDR_ACTIVE_LENGTH;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_length_reg();
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {25'd0, active_len}) begin
            mismatches++;
            $display("%0t: active_length readback: expected %0d, actual %0d",
                     $realtime, active_len, rd);
        end
    endtask

    task automatic set_active_length(input logic [31:0] v);
        logic [31:0] rd;
        wait_idle();
        apb_xfer(1'b1, v, rd);
        active_len = v[vst_pkg::ALEN_W-1:0];
        check_length_reg();
    endtask

    task automatic check_field(input string what, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $realtime, what, exp_v, act_v);
        end
    endtask

    // driver: offer queued commands, hold a beat while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
        end else begin
            if (req_valid && !req_stall) begin
                pending_results = {pending_results, apply_command(req)};
                cmd_tally[req.cmd]++;
            end
            if (!req_valid || !req_stall) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    req <= cmd_queue.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result beats in order and drive the receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d",
                             $realtime, rsp.read_value, rsp.snap_number, rsp.status);
                end else begin
                    want = pending_results.pop_front();
                    status_seen[want.status]++;
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("snap_number", want.snap_number, rsp.snap_number);
                    check_field("status", want.status, rsp.status);
                end
            end
            // one long hold-off so the block backs up into its input
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // watchdog: no beat moving on either channel for too long
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (hist_len[i])
            hist_len[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_length_reg();

        // directed: empty table, overwrite, append, lookups, future ids, unused command
        tx_idle_pct = 18;
        rx_idle_pct = 69;
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SNAP, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd0, 32'h7FFF_FFFF, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd0, 32'h8000_0000, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd63, 32'hFFFF_FFFF, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SNAP, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd0, 32'd12345, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SNAP, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd1));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd2));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd63, 32'd0, 16'd2));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd3));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'hFFFF));
        push_item(mk_cmd(vst_pkg::CMD_UNUSED, 6'd63, 32'hFFFF_FFFF, 16'hFFFF));

        // single live entry: indexes past it are rejected
        set_active_length(32'd1);
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd1, 32'd7, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd63, 32'd0, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd0, 32'd5, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd2));
        run_random(150);

        // zero length rejects every index
        set_active_length(32'd0);
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd0, 32'd9, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd0, 32'd0, 16'd0));
        run_random(60);

        // oversized length behaves as the full table
        set_active_length(32'd127);
        push_item(mk_cmd(vst_pkg::CMD_SET, 6'd63, 32'h5555_5555, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, 6'd63, 32'd0, 16'd2));
        run_random(300);

        tx_idle_pct = 69;
        rx_idle_pct = 18;
        set_active_length(32'd33);
        run_random(400);
        set_active_length(32'd64);
        run_random(400);

        // no idling; the long receiver hold-off lands in here
        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(700);

        // closing commands: a set, then far-future ids and an unused command on a hot entry
        wait_idle();
        push_item(mk_cmd(vst_pkg::CMD_SET, hot_idx[0], 32'hA5A5_A5A5, 16'd0));
        push_item(mk_cmd(vst_pkg::CMD_GET, hot_idx[0], 32'd0, 16'hFFFE));
        push_item(mk_cmd(vst_pkg::CMD_GET, hot_idx[0], 32'd0, 16'hFFFF));
        push_item(mk_cmd(vst_pkg::CMD_UNUSED, hot_idx[0], 32'd0, 16'd0));

        // drain and settle
        while (cmd_queue.size() > 0 || req_valid || pending_results.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_results.size() > 0) begin
            mismatches += pending_results.size();
            $display("%0t: %0d expected results never arrived",
                     $realtime, pending_results.size());
        end

        $display("Ran %0d set, %0d snap, %0d get, %0d unused commands; %0d results checked",
                 cmd_tally[vst_pkg::CMD_SET], cmd_tally[vst_pkg::CMD_SNAP],
                 cmd_tally[vst_pkg::CMD_GET], cmd_tally[vst_pkg::CMD_UNUSED], results_seen);
        $display("Status mix: ok %0d, bad index %0d, history full %0d, snapshot %0d; counter %0d",
                 status_seen[vst_pkg::ST_OK], status_seen[vst_pkg::ST_BADIDX],
                 status_seen[vst_pkg::ST_FULL], status_seen[vst_pkg::ST_SNAP], snap_count);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
